// ----- rtl/spp_pkg.sv -----
// shared types, constants and saturation helper for the stereo ping-pong delay
`timescale 1ns / 1ps
`default_nettype none

package spp_pkg;

    localparam int LINE_DEPTH  = 131072;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int SAMPLE_BITS = 24;
    localparam int DELAY_W     = 17;
    localparam int FB_W        = 15;
    localparam int WET_W       = 16;
    localparam int GAIN_W      = WET_W + 1;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W;
    localparam int SHIFT       = 15;
    localparam int SUM_W       = PROD_W - SHIFT + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DELAY_W;

    localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(16800);
    localparam logic [FB_W-1:0]    FB_RST    = FB_W'(11469);
    localparam logic [WET_W-1:0]   WET_RST   = WET_W'(6554);
    localparam logic [FB_W-1:0]    FB_MAX    = FB_W'(31129);
    localparam logic [WET_W-1:0]   GAIN_ONE  = WET_W'(32768);
    localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'(LINE_DEPTH - 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } frame_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_WET      = 2'd2
    } cfg_reg_t;

    // clip a widened sum back to the sample range
    function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-SAMPLE_BITS:0] top;
        top = v[SUM_W-1:SAMPLE_BITS-1];
        if ((&top) || (~|top)) begin
            return v[SAMPLE_BITS-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/spp_line_mem.sv -----
// both delay lines side by side in one synchronous single-port-write memory
`timescale 1ns / 1ps
`default_nettype none

module spp_line_mem
    import spp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire frame_t            wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output frame_t                 rd_data
);

    frame_t mem_array [LINE_DEPTH];
    frame_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/spp_mix.sv -----
// gain products, registered, then shift, sum and saturate for line and output
`timescale 1ns / 1ps
`default_nettype none

module spp_mix
    import spp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             load,
    input  wire frame_t           dry_in,
    input  wire frame_t           dly_in,
    input  wire logic [FB_W-1:0]  fb,
    input  wire logic [WET_W-1:0] wet,
    output frame_t                line_wr,
    output frame_t                mix_out
);

    logic signed [GAIN_W-1:0] fb_s;
    logic signed [GAIN_W-1:0] wet_s;
    logic signed [GAIN_W-1:0] dry_s;

    logic signed [PROD_W-1:0] fb_l_reg;
    logic signed [PROD_W-1:0] fb_r_reg;
    logic signed [PROD_W-1:0] wet_l_reg;
    logic signed [PROD_W-1:0] wet_r_reg;
    logic signed [PROD_W-1:0] dry_l_reg;
    logic signed [PROD_W-1:0] dry_r_reg;
    sample_t                  in_l_reg;
    sample_t                  in_r_reg;

    logic signed [SUM_W-1:0] line_l_sum;
    logic signed [SUM_W-1:0] line_r_sum;
    logic signed [SUM_W-1:0] out_l_sum;
    logic signed [SUM_W-1:0] out_r_sum;

    assign fb_s  = $signed({2'b00, fb});
    assign wet_s = $signed({1'b0, wet});
    assign dry_s = $signed({1'b0, GAIN_ONE - wet});

    // cross feedback: left line takes the delayed right sample and vice versa
    always_ff @(posedge aclk) begin
        if (load) begin
            fb_l_reg  <= PROD_W'(dly_in.right) * PROD_W'(fb_s);
            fb_r_reg  <= PROD_W'(dly_in.left)  * PROD_W'(fb_s);
            wet_l_reg <= PROD_W'(dly_in.left)  * PROD_W'(wet_s);
            wet_r_reg <= PROD_W'(dly_in.right) * PROD_W'(wet_s);
            dry_l_reg <= PROD_W'(dry_in.left)  * PROD_W'(dry_s);
            dry_r_reg <= PROD_W'(dry_in.right) * PROD_W'(dry_s);
            in_l_reg  <= dry_in.left;
            in_r_reg  <= dry_in.right;
        end
    end

    always_comb begin
        line_l_sum = SUM_W'(in_l_reg) + SUM_W'($signed(fb_l_reg[PROD_W-1:SHIFT]));
        line_r_sum = SUM_W'(in_r_reg) + SUM_W'($signed(fb_r_reg[PROD_W-1:SHIFT]));
        out_l_sum  = SUM_W'($signed(dry_l_reg[PROD_W-1:SHIFT]))
                   + SUM_W'($signed(wet_l_reg[PROD_W-1:SHIFT]));
        out_r_sum  = SUM_W'($signed(dry_r_reg[PROD_W-1:SHIFT]))
                   + SUM_W'($signed(wet_r_reg[PROD_W-1:SHIFT]));
        line_wr.left   = sat_sample(line_l_sum);
        line_wr.right  = sat_sample(line_r_sum);
        mix_out.left   = sat_sample(out_l_sum);
        mix_out.right  = sat_sample(out_r_sum);
    end

endmodule

`default_nettype wire

// ----- rtl/stereo_ping_pong_delay.sv -----
// Stereo ping-pong delay with cross feedback.
// Input requests carry one stereo frame (s_left_in, s_right_in) on a valid/ready
// channel; each accepted frame yields exactly one mixed frame on the m_ channel.
// Configuration: cfg_wr_en with cfg_index (0 delay, 1 feedback, 2 wet) and
// cfg_data; the user writes only while no frame is in flight, the block does
// not enforce this. An accepted frame passes the memory read at the accepting
// edge, the gain product registers, then sum and saturate into the output
// register, where m_valid rises. Throughput: one frame per cycle for a delay of
// two samples or more while m_ready stays high; with a delay of one sample the
// next frame waits until the previous one writes the entry that it reads.
// Both lines sit in one 131072 x 48 bit memory. After reset the block is ready
// at once: entries not yet written since reset read as zero, tracked by the
// write pointer and a wrapped flag, so no clearing pass is needed.
// When the receiver stalls, the output register holds and the two inner stages
// keep filling, so up to three frames are held before s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module stereo_ping_pong_delay
    import spp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sample_t               s_left_in,
    input  wire sample_t               s_right_in,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sample_t                    m_left_out,
    output sample_t                    m_right_out,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DELAY_W-1:0] delay_reg;
    logic [FB_W-1:0]    fb_reg;
    logic [WET_W-1:0]   wet_reg;

    logic [ADDR_W-1:0] wp_reg;
    logic              wrapped_reg;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_wp_reg;
    logic [ADDR_W-1:0] s1_rp_reg;
    logic              s1_filled_reg;
    frame_t            s1_in_reg;

    logic              s2_valid_reg;
    logic [ADDR_W-1:0] s2_wp_reg;

    logic              out_valid_reg;
    frame_t            out_reg;

    logic              byp_valid_reg;
    logic [ADDR_W-1:0] byp_addr_reg;
    frame_t            byp_data_reg;

    logic [DELAY_W-1:0] delay_eff;
    logic [FB_W-1:0]    fb_eff;
    logic [WET_W-1:0]   wet_eff;
    logic [ADDR_W-1:0]  rp_new;
    logic               out_adv;
    logic               s2_adv;
    logic               s1_adv;
    logic               wr_now;
    logic               hazard;
    logic               accept;
    frame_t             rd_data;
    frame_t             dly;
    frame_t             in_frame;
    frame_t             line_wr;
    frame_t             mix_out;

    always_comb begin
        if (delay_reg == '0) begin
            delay_eff = DELAY_W'(1);
        end else if (delay_reg > DELAY_MAX) begin
            delay_eff = DELAY_MAX;
        end else begin
            delay_eff = delay_reg;
        end
        fb_eff  = (fb_reg > FB_MAX) ? FB_MAX : fb_reg;
        wet_eff = (wet_reg > GAIN_ONE) ? GAIN_ONE : wet_reg;
    end

    assign rp_new = wp_reg - delay_eff[ADDR_W-1:0];

    assign out_adv = !out_valid_reg || m_ready;
    assign s2_adv  = !s2_valid_reg || out_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign wr_now  = s2_valid_reg && out_adv;

    // hold off a frame whose read entry is owed a write that the memory will miss
    assign hazard = (s1_valid_reg && (s1_wp_reg == rp_new))
                 || (s2_valid_reg && !out_adv && (s2_wp_reg == rp_new));

    assign s_ready = s1_adv && !hazard;
    assign accept  = s_valid && s_ready;

    assign in_frame.left  = s_left_in;
    assign in_frame.right = s_right_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RST;
            fb_reg    <= FB_RST;
            wet_reg   <= WET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DELAY: begin
                    delay_reg <= cfg_data[DELAY_W-1:0];
                end
                REG_FEEDBACK: begin
                    fb_reg <= cfg_data[FB_W-1:0];
                end
                REG_WET: begin
                    wet_reg <= cfg_data[WET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                wp_reg <= wp_reg + ADDR_W'(1);
                if (&wp_reg) begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (s1_adv) begin
                s1_valid_reg <= accept;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv) begin
                out_valid_reg <= s2_valid_reg;
            end
            if (wr_now) begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_wp_reg     <= wp_reg;
            s1_rp_reg     <= rp_new;
            s1_filled_reg <= wrapped_reg || (rp_new < wp_reg);
            s1_in_reg     <= in_frame;
        end
        if (s2_adv && s1_valid_reg) begin
            s2_wp_reg <= s1_wp_reg;
        end
        if (out_adv && s2_valid_reg) begin
            out_reg <= mix_out;
        end
        if (wr_now) begin
            byp_addr_reg <= s2_wp_reg;
            byp_data_reg <= line_wr;
        end
    end

    // newest write wins over the memory word; never-written entries read zero
    always_comb begin
        if (byp_valid_reg && (byp_addr_reg == s1_rp_reg)) begin
            dly = byp_data_reg;
        end else if (s1_filled_reg) begin
            dly = rd_data;
        end else begin
            dly = '0;
        end
    end

    spp_line_mem u_line_mem (
        .aclk    (aclk),
        .wr_en   (wr_now),
        .wr_addr (s2_wp_reg),
        .wr_data (line_wr),
        .rd_en   (accept),
        .rd_addr (rp_new),
        .rd_data (rd_data)
    );

    spp_mix u_mix (
        .aclk    (aclk),
        .load    (s2_adv && s1_valid_reg),
        .dry_in  (s1_in_reg),
        .dly_in  (dly),
        .fb      (fb_eff),
        .wet     (wet_eff),
        .line_wr (line_wr),
        .mix_out (mix_out)
    );

    assign m_valid     = out_valid_reg;
    assign m_left_out  = out_reg.left;
    assign m_right_out = out_reg.right;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// self-checking testbench for the stereo ping-pong delay
`timescale 1ns / 1ps

module tb;
    import spp_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam int STALL_LIMIT    = 2000;
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_FRAMES = 175;
    localparam int MAX_GAP        = 20;
    localparam int REPORT_LIMIT   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum int {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        frame_t                stim;
        bit                    has_exp;
        frame_t                want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sample_t               s_left_in;
    sample_t               s_right_in;
    logic                  m_valid;
    logic                  m_ready;
    sample_t               m_left_out;
    sample_t               m_right_out;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    sample_t            echo_left  [LINE_DEPTH];
    sample_t            echo_right [LINE_DEPTH];
    int unsigned        head_pos;
    logic [DELAY_W-1:0] delay_reg;
    logic [FB_W-1:0]    fb_reg;
    logic [WET_W-1:0]   wet_reg;
    frame_t             mix_q [$];

    // typed expectation for the frame currently on the request bus
    bit     fixed_valid;
    frame_t fixed_mix;

    pace_t pace;
    int    err_cnt = 0;
    int    result_cnt = 0;
    int    quiet_cycles = 0;

    stereo_ping_pong_delay uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic sample_t clip(longint v);
        if (v > longint'(S_MAX)) return S_MAX;
        if (v < longint'(S_MIN)) return S_MIN;
        return sample_t'(v);
    endfunction

    // Q1.15 product, floor division by 32768
    function automatic longint scale(longint s, longint g);
        return (s * g) >>> SHIFT;
    endfunction

    function automatic frame_t echo_step(frame_t dry_in);
        int unsigned d;
        int unsigned rp;
        longint      fb;
        longint      wet;
        longint      dry;
        longint      in_l;
        longint      in_r;
        longint      tap_l;
        longint      tap_r;
        frame_t      mix;
        d = delay_reg;
        if (d == 0) d = 1;
        if (d > LINE_DEPTH - 1) d = LINE_DEPTH - 1;
        fb = (fb_reg > FB_MAX) ? FB_MAX : fb_reg;
        wet = (wet_reg > GAIN_ONE) ? GAIN_ONE : wet_reg;
        dry = longint'(GAIN_ONE) - wet;
        in_l = dry_in.left;
        in_r = dry_in.right;
        rp = (head_pos + LINE_DEPTH - d) % LINE_DEPTH;
        tap_l = echo_left[rp];
        tap_r = echo_right[rp];
        // cross feedback: each line takes the other side's tap
        echo_left[head_pos] = clip(in_l + scale(tap_r, fb));
        echo_right[head_pos] = clip(in_r + scale(tap_l, fb));
        mix.left = clip(scale(in_l, dry) + scale(tap_l, wet));
        mix.right = clip(scale(in_r, dry) + scale(tap_r, wet));
        head_pos = (head_pos + 1) % LINE_DEPTH;
        return mix;
    endfunction

    function automatic int idle_pct(bit receiver_side);
        case (pace)
            PACE_BOTH: return 10;
            PACE_SENDER: return receiver_side ? 0 : 60;
            PACE_RECEIVER: return receiver_side ? 60 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic sample_t pick_sample();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return sample_t'($urandom);
        if (roll < 85) begin
            case ($urandom_range(0, 3))
                0: return S_MAX;
                1: return S_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return sample_t'($urandom_range(0, 2000) - 1000);
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        r.stim = '0;
        r.has_exp = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t frame_row(sample_t l, sample_t rt, bit has_exp = 1'b0,
                                            sample_t el = '0, sample_t er = '0);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.idx = '0;
        r.data = '0;
        r.stim = {l, rt};
        r.has_exp = has_exp;
        r.want = {el, er};
        return r;
    endfunction

    task automatic report_error(string msg);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_DELAY: delay_reg = data[DELAY_W-1:0];
            REG_FEEDBACK: fb_reg = data[FB_W-1:0];
            REG_WET: wet_reg = data[WET_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain_echoes();
        s_valid <= 1'b0;
        while (mix_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // called at a falling edge; leaves valid high so a following frame can go back to back
    task automatic send_frame(frame_t f, bit typed, frame_t want);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct(1'b0)) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_left_in <= f.left;
        s_right_in <= f.right;
        fixed_valid = typed;
        fixed_mix = want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end

    always @(posedge aclk) begin
        frame_t mix;
        frame_t want;
        if (aresetn) begin
            quiet_cycles++;
            if (s_valid && s_ready) begin
                mix = echo_step({s_left_in, s_right_in});
                mix_q.push_back(fixed_valid ? fixed_mix : mix);
                quiet_cycles = 0;
            end
            if (m_valid && m_ready) begin
                quiet_cycles = 0;
                result_cnt++;
                if (mix_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none expected",
                                           result_cnt));
                end else begin
                    want = mix_q.pop_front();
                    if (m_left_out !== want.left)
                        report_error($sformatf("result %0d left_out: got %0d, expected %0d",
                                               result_cnt, m_left_out, want.left));
                    if (m_right_out !== want.right)
                        report_error($sformatf("result %0d right_out: got %0d, expected %0d",
                                               result_cnt, m_right_out, want.right));
                end
            end
        end
    end

    initial begin
        do @(posedge aclk); while (quiet_cycles < STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        plan_row_t          plan [$];
        logic [DELAY_W-1:0] dval;
        logic [CFG_DATA_W-1:0] gval;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_left_in = '0;
        s_right_in = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fixed_valid = 1'b0;
        fixed_mix = '0;
        pace = PACE_FULL;
        head_pos = 0;
        delay_reg = DELAY_RST;
        fb_reg = FB_RST;
        wet_reg = WET_RST;
        foreach (echo_left[i]) begin
            echo_left[i] = '0;
            echo_right[i] = '0;
        end

        // reset gains: dry 26214, taps still empty
        plan.push_back(frame_row('0, '0, 1'b1, '0, '0));
        plan.push_back(frame_row(S_MAX, S_MIN, 1'b1, 24'sd6710783, -24'sd6710784));
        plan.push_back(frame_row(24'sd1, -24'sd1, 1'b1, '0, -24'sd1));
        // fully dry passes the input through
        plan.push_back(cfg_row(REG_WET, '0));
        plan.push_back(frame_row(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN));
        plan.push_back(frame_row(-24'sd1, 24'sd1, 1'b1, -24'sd1, 24'sd1));
        // shortest delay, no feedback, fully wet
        plan.push_back(cfg_row(REG_FEEDBACK, '0));
        plan.push_back(cfg_row(REG_DELAY, 17'd1));
        plan.push_back(cfg_row(REG_WET, CFG_DATA_W'(GAIN_ONE)));
        plan.push_back(frame_row(24'sd123, -24'sd456));
        plan.push_back(frame_row(S_MAX, S_MAX));
        plan.push_back(frame_row(S_MIN, S_MIN));
        // clamps: zero delay, feedback and wet above their limits, bits above width
        plan.push_back(cfg_row(REG_FEEDBACK, '1));
        plan.push_back(cfg_row(REG_WET, '1));
        plan.push_back(cfg_row(REG_DELAY, '0));
        plan.push_back(frame_row(S_MAX, S_MAX));
        plan.push_back(frame_row(S_MAX, S_MAX));
        plan.push_back(frame_row(S_MAX, S_MAX));
        plan.push_back(frame_row(S_MIN, S_MIN));
        plan.push_back(frame_row(S_MIN, S_MIN));
        plan.push_back(frame_row(S_MIN, S_MIN));
        plan.push_back(frame_row(S_MAX, S_MIN));
        plan.push_back(frame_row('0, '0));
        // write to an unused index must change nothing
        plan.push_back(cfg_row(REG_NONE, '1));
        plan.push_back(frame_row(24'sd77, -24'sd77));
        // longest delay lands on a never-written entry
        plan.push_back(cfg_row(REG_DELAY, DELAY_MAX));
        plan.push_back(frame_row(24'sd5, -24'sd5, 1'b1, '0, '0));
        plan.push_back(cfg_row(REG_DELAY, 17'd2));
        plan.push_back(cfg_row(REG_WET, 17'd16384));
        plan.push_back(cfg_row(REG_FEEDBACK, CFG_DATA_W'(FB_MAX)));
        plan.push_back(frame_row(24'sd4000000, -24'sd4000000));
        plan.push_back(frame_row(-24'sd3000000, 24'sd2500000));
        plan.push_back(frame_row(S_MAX, S_MIN));
        plan.push_back(frame_row(24'sd12345, -24'sd54321));

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_echoes();
                cfg_write(plan[i].idx, plan[i].data);
            end else begin
                send_frame(plan[i].stim, plan[i].has_exp, plan[i].want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_echoes();
            pace = pace_t'(seg % 4);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: dval = DELAY_W'($urandom_range(1, 16));
                5, 6: dval = DELAY_W'($urandom_range(1, 2));
                // can reach back past the first frame into entries never written
                7, 8: dval = DELAY_W'($urandom_range(1, head_pos + 8));
                default: dval = DELAY_W'($urandom_range(0, DELAY_MAX));
            endcase
            cfg_write(REG_DELAY, dval);
            case ($urandom_range(0, 5))
                0: gval = '0;
                1: gval = CFG_DATA_W'(FB_MAX);
                2: gval = '1;
                3, 4: gval = CFG_DATA_W'($urandom_range(0, FB_MAX));
                default: gval = CFG_DATA_W'($urandom);
            endcase
            cfg_write(REG_FEEDBACK, gval);
            case ($urandom_range(0, 5))
                0: gval = '0;
                1: gval = CFG_DATA_W'(GAIN_ONE);
                2: gval = '1;
                3, 4: gval = CFG_DATA_W'($urandom_range(0, GAIN_ONE));
                default: gval = CFG_DATA_W'($urandom);
            endcase
            cfg_write(REG_WET, gval);
            if ($urandom_range(0, 3) == 0) cfg_write(REG_NONE, CFG_DATA_W'($urandom));
            repeat (SEGMENT_FRAMES) send_frame({pick_sample(), pick_sample()}, 1'b0, '0);
        end

        drain_echoes();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- stereo_ping_pong_delay.f -----
rtl/spp_pkg.sv
rtl/spp_line_mem.sv
rtl/spp_mix.sv
rtl/stereo_ping_pong_delay.sv
sim/tb.sv
